/* hw/rtl/scoc_pkg.sv */
`timescale 1ns / 1ps

package scoc_pkg;

    // One input beat: one byte of the algorithm identifier.
    typedef struct packed {
        logic [7:0] oid_byte;
        logic       last_byte;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic       recognized;
        logic [3:0] curve_code;
    } t_out_beat;

    // Which key algorithm OID was found at offset 2.
    typedef enum logic [1:0] {
        KB_NONE  = 2'd0,
        KB_ECPK  = 2'd1,
        KB_G2012 = 2'd2,
        KB_G2001 = 2'd3
    } t_key_branch;

    // Curve codes.
    localparam logic [3:0] CURVE_P256      = 4'd0;
    localparam logic [3:0] CURVE_P384      = 4'd1;
    localparam logic [3:0] CURVE_P521      = 4'd2;
    localparam logic [3:0] CURVE_SM2       = 4'd3;
    localparam logic [3:0] CURVE_X25519    = 4'd4;
    localparam logic [3:0] CURVE_X448      = 4'd5;
    localparam logic [3:0] CURVE_GOSTA     = 4'd6;
    localparam logic [3:0] CURVE_GOSTXCHA  = 4'd7;
    localparam logic [3:0] CURVE_GOST2012A = 4'd8;
    localparam logic [3:0] CURVE_GOSTTEST  = 4'd9;

    // Fixed pattern ids (bit positions in the prefix match flags).
    localparam int NUM_PAT   = 9;
    localparam int PAT_ED448 = 0;
    localparam int PAT_ED255 = 1;
    localparam int PAT_ECPK  = 2;
    localparam int PAT_P256  = 3;
    localparam int PAT_P384  = 4;
    localparam int PAT_P521  = 5;
    localparam int PAT_SM2   = 6;
    localparam int PAT_G2012 = 7;
    localparam int PAT_G2001 = 8;

    localparam int NUM_CAND = 5;

    // Element walk starts right after the two-byte sequence header.
    localparam logic [4:0] G2012_LIST_START = 5'd14;
    localparam logic [4:0] G2001_LIST_START = 5'd12;

    // Total identifier lengths for the fixed forms.
    localparam logic [4:0] LEN_ED     = 5'd7;
    localparam logic [4:0] LEN_EC_LONG  = 5'd21;
    localparam logic [4:0] LEN_EC_SHORT = 5'd18;

    function automatic logic [4:0] pat_off(input logic [3:0] id);
        unique case (id)
            PAT_ED448, PAT_ED255:                 pat_off = 5'd0;
            PAT_ECPK, PAT_G2012, PAT_G2001:       pat_off = 5'd2;
            PAT_P256, PAT_P384, PAT_P521, PAT_SM2: pat_off = 5'd11;
            default:                              pat_off = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] pat_len(input logic [3:0] id);
        unique case (id)
            PAT_ED448, PAT_ED255, PAT_P384, PAT_P521: pat_len = 5'd7;
            PAT_ECPK:                                 pat_len = 5'd9;
            PAT_P256, PAT_SM2, PAT_G2012:             pat_len = 5'd10;
            PAT_G2001:                                pat_len = 5'd8;
            default:                                  pat_len = 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] pat_byte(input logic [3:0] id, input logic [3:0] k);
        logic [7:0] p [10];
        p = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        unique case (id)
            PAT_ED448: p = '{8'h30, 8'h05, 8'h06, 8'h03, 8'h2b, 8'h65, 8'h71, 8'h00, 8'h00, 8'h00};
            PAT_ED255: p = '{8'h30, 8'h05, 8'h06, 8'h03, 8'h2b, 8'h65, 8'h70, 8'h00, 8'h00, 8'h00};
            PAT_ECPK:  p = '{8'h06, 8'h07, 8'h2a, 8'h86, 8'h48, 8'hce, 8'h3d, 8'h02, 8'h01, 8'h00};
            PAT_P256:  p = '{8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'hce, 8'h3d, 8'h03, 8'h01, 8'h07};
            PAT_P384:  p = '{8'h06, 8'h05, 8'h2b, 8'h81, 8'h04, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00};
            PAT_P521:  p = '{8'h06, 8'h05, 8'h2b, 8'h81, 8'h04, 8'h00, 8'h23, 8'h00, 8'h00, 8'h00};
            PAT_SM2:   p = '{8'h06, 8'h08, 8'h2a, 8'h81, 8'h1c, 8'hcf, 8'h55, 8'h01, 8'h82, 8'h2d};
            PAT_G2012: p = '{8'h06, 8'h08, 8'h2a, 8'h85, 8'h03, 8'h07, 8'h01, 8'h01, 8'h01, 8'h01};
            PAT_G2001: p = '{8'h06, 8'h06, 8'h2a, 8'h85, 8'h03, 8'h02, 8'h02, 8'h13, 8'h00, 8'h00};
            default: ;
        endcase
        pat_byte = (k < 4'd10) ? p[k] : 8'h00;
    endfunction

    function automatic logic [3:0] cand_len(input logic [2:0] id);
        cand_len = (id == 3'd3) ? 4'd11 : 4'd9;
    endfunction

    function automatic logic [3:0] cand_code(input logic [2:0] id);
        unique case (id)
            3'd0, 3'd1: cand_code = CURVE_GOSTA;
            3'd2:       cand_code = CURVE_GOSTXCHA;
            3'd3:       cand_code = CURVE_GOST2012A;
            3'd4:       cand_code = CURVE_GOSTTEST;
            default:    cand_code = CURVE_P256;
        endcase
    endfunction

    function automatic logic [7:0] cand_byte(input logic [2:0] id, input logic [3:0] k);
        logic [7:0] p [11];
        p = '{8'h06, 8'h07, 8'h2a, 8'h85, 8'h03, 8'h02, 8'h02, 8'h23, 8'h01, 8'h00, 8'h00};
        unique case (id)
            3'd0: p = '{8'h06, 8'h07, 8'h2a, 8'h85, 8'h03, 8'h02, 8'h02, 8'h23, 8'h01,
                        8'h00, 8'h00};
            3'd1: p = '{8'h06, 8'h07, 8'h2a, 8'h85, 8'h03, 8'h02, 8'h02, 8'h1f, 8'h01,
                        8'h00, 8'h00};
            3'd2: p = '{8'h06, 8'h07, 8'h2a, 8'h85, 8'h03, 8'h02, 8'h02, 8'h24, 8'h00,
                        8'h00, 8'h00};
            3'd3: p = '{8'h06, 8'h09, 8'h2a, 8'h85, 8'h03, 8'h07, 8'h01, 8'h02, 8'h01,
                        8'h01, 8'h01};
            3'd4: p = '{8'h06, 8'h07, 8'h2a, 8'h85, 8'h03, 8'h02, 8'h02, 8'h23, 8'h00,
                        8'h00, 8'h00};
            default: ;
        endcase
        cand_byte = (k < 4'd11) ? p[k] : 8'h00;
    endfunction

endpackage

/* hw/rtl/spki_curve_oid_classifier.sv */
`timescale 1ns / 1ps

// Curve classifier for the DER bytes of a public-key algorithm identifier.
// Feed one byte per input beat and mark the final byte with last_byte; the
// block returns exactly one result beat per identifier, on its last byte,
// and nothing for the other bytes. It recognizes the seven-byte Ed448 and
// Ed25519 forms, ecPublicKey followed by exactly one of secp256r1,
// secp384r1, secp521r1 or sm2p256v1, and the two GOST key OIDs, whose
// parameter-set list is walked element by element by its length bytes;
// the first element that equals a known parameter set names the curve.
// A walk that runs past the end, a cut-short element, or an identifier
// longer than MAX_OID_BYTES gives recognized = 0 and curve_code = 0.
// Throughput is one byte per clock: every byte is handled by constant
// compares and a few small counters between the input register and the
// result register. A byte that is not last always moves on; a last byte
// waits only while the result register is full and held by i_out_stall.
// The verdict on the held last byte is loaded into the result register.
// Per-identifier state clears itself after each last byte; no clearing
// pass is needed after reset.
module spki_curve_oid_classifier #(
    parameter int MAX_OID_BYTES = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  scoc_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output scoc_pkg::t_out_beat  o_out_data
);
    import scoc_pkg::*;

    // Byte counter saturates at MAX_OID_BYTES + 1.
    localparam int PW = $clog2(MAX_OID_BYTES + 2);
    // Element offsets can reach the saturated position plus a header and 255 bytes.
    localparam int EW = $clog2(MAX_OID_BYTES + 260);

    // Input register and result register.
    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;
    t_out_beat  n_out;

    // Per-identifier state.
    logic [PW-1:0]       r_pos, n_pos;
    logic [NUM_PAT-1:0]  r_flags, n_flags;
    t_key_branch         r_kb, n_kb;
    logic [EW-1:0]       r_es, n_es;
    logic [EW-1:0]       r_en, n_en;
    logic [NUM_CAND-1:0] r_cand, n_cand;
    logic                r_found, n_found;
    logic [3:0]          r_fc, n_fc;

    logic out_free;
    logic advance;

    // Move the held byte on when it makes no result, or when the result
    // register is empty or being drained this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Byte classification: pattern flags, key branch, element walk, verdict.
    always_comb begin
        logic [PW-1:0]  pos;
        logic [PW-1:0]  rel;
        logic [7:0]     b;
        logic [EW-1:0]  epos;
        logic [EW-1:0]  k;
        logic [PW:0]    len;
        logic           hit;
        logic           walk;

        pos  = r_pos;
        b    = r_in.oid_byte;
        epos = EW'(r_pos);
        k    = '0;
        rel  = '0;
        hit  = 1'b0;

        n_pos   = r_pos;
        n_flags = r_flags;
        n_kb    = r_kb;
        n_es    = r_es;
        n_en    = r_en;
        n_cand  = r_cand;
        n_found = r_found;
        n_fc    = r_fc;
        n_out   = '0;

        if (r_pos <= PW'(MAX_OID_BYTES)) begin
            n_pos = r_pos + PW'(1);
        end

        // Drop any fixed pattern that disagrees with this byte.
        for (int j = 0; j < NUM_PAT; j++) begin
            if (pos >= PW'(pat_off(4'(j))) &&
                pos <  PW'(pat_off(4'(j)) + pat_len(4'(j)))) begin
                rel = pos - PW'(pat_off(4'(j)));
                if (pat_byte(4'(j), rel[3:0]) != b) begin
                    n_flags[j] = 1'b0;
                end
            end
        end

        // Key OID completes on its last byte.
        if (pos == PW'(pat_off(4'(PAT_ECPK)) + pat_len(4'(PAT_ECPK)) - 5'd1) &&
            n_flags[PAT_ECPK]) begin
            n_kb = KB_ECPK;
        end
        if (pos == PW'(pat_off(4'(PAT_G2012)) + pat_len(4'(PAT_G2012)) - 5'd1) &&
            n_flags[PAT_G2012]) begin
            n_kb = KB_G2012;
            n_en = EW'(G2012_LIST_START);
        end
        if (pos == PW'(pat_off(4'(PAT_G2001)) + pat_len(4'(PAT_G2001)) - 5'd1) &&
            n_flags[PAT_G2001]) begin
            n_kb = KB_G2001;
            n_en = EW'(G2001_LIST_START);
        end

        walk = (n_kb == KB_G2012 && pos >= PW'(G2012_LIST_START)) ||
               (n_kb == KB_G2001 && pos >= PW'(G2001_LIST_START));

        // Parameter-set walk; once a set has matched, later bytes are ignored.
        if (walk && !r_found) begin
            if (epos == n_en) begin
                n_es   = epos;
                n_cand = (n_kb == KB_G2012) ? 5'h1f : 5'h0f;
            end
            if (epos >= n_es) begin
                k = epos - n_es;
                if (k == EW'(1)) begin
                    n_en = n_es + EW'(2) + EW'(b);
                end
                for (int i = 0; i < NUM_CAND; i++) begin
                    if (!hit && n_cand[i]) begin
                        if (k >= EW'(cand_len(3'(i))) ||
                            cand_byte(3'(i), k[3:0]) != b) begin
                            n_cand[i] = 1'b0;
                        end else if (k == EW'(cand_len(3'(i)) - 4'd1)) begin
                            hit     = 1'b1;
                            n_found = 1'b1;
                            n_fc    = cand_code(3'(i));
                        end
                    end
                end
            end
        end

        // Verdict on the last byte.
        len = (PW+1)'(n_pos);
        if (len <= (PW+1)'(MAX_OID_BYTES)) begin
            if (len == (PW+1)'(LEN_ED) && n_flags[PAT_ED448]) begin
                n_out = '{recognized: 1'b1, curve_code: CURVE_X448};
            end else if (len == (PW+1)'(LEN_ED) && n_flags[PAT_ED255]) begin
                n_out = '{recognized: 1'b1, curve_code: CURVE_X25519};
            end else if (n_kb == KB_ECPK) begin
                if (len == (PW+1)'(LEN_EC_LONG) && n_flags[PAT_P256]) begin
                    n_out = '{recognized: 1'b1, curve_code: CURVE_P256};
                end else if (len == (PW+1)'(LEN_EC_SHORT) && n_flags[PAT_P384]) begin
                    n_out = '{recognized: 1'b1, curve_code: CURVE_P384};
                end else if (len == (PW+1)'(LEN_EC_SHORT) && n_flags[PAT_P521]) begin
                    n_out = '{recognized: 1'b1, curve_code: CURVE_P521};
                end else if (len == (PW+1)'(LEN_EC_LONG) && n_flags[PAT_SM2]) begin
                    n_out = '{recognized: 1'b1, curve_code: CURVE_SM2};
                end
            end else if ((n_kb == KB_G2012 || n_kb == KB_G2001) && n_found) begin
                n_out = '{recognized: 1'b1, curve_code: n_fc};
            end
        end
    end

    // Input register: take a new beat when empty or when the held one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register: load on a last byte, drop when taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    // Per-identifier state: advance on each byte, clear after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in.last_byte)) begin
            r_pos   <= '0;
            r_flags <= '1;
            r_kb    <= KB_NONE;
            r_es    <= '0;
            r_en    <= '0;
            r_cand  <= '1;
            r_found <= 1'b0;
            r_fc    <= '0;
        end else if (advance) begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_kb    <= n_kb;
            r_es    <= n_es;
            r_en    <= n_en;
            r_cand  <= n_cand;
            r_found <= n_found;
            r_fc    <= n_fc;
        end
    end

`ifndef SYNTH
    a_unrec_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.recognized) |-> (o_out_data.curve_code == 4'd0))
        else $error("unrecognized result carries a nonzero curve code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.curve_code <= CURVE_GOSTTEST))
        else $error("curve code out of range");

    a_found_needs_gost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_kb == KB_G2012 || r_kb == KB_G2001))
        else $error("parameter set matched outside a GOST key branch");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.last_byte) |=> (r_pos == '0 && r_kb == KB_NONE && !r_found))
        else $error("identifier state not cleared after last byte");

    a_test_set_2012: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && r_fc == CURVE_GOSTTEST) |-> (r_kb == KB_G2012))
        else $error("test parameter set matched under the 2001 key");
`endif

endmodule
